/* hdl/mecanum_wheel_mixer_macros.svh */
// assertion macros shared by the mecanum wheel mixer checkers
`ifndef MECANUM_WHEEL_MIXER_MACROS_SVH
`define MECANUM_WHEEL_MIXER_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define MWM_ASSERT_NOW(lbl, ant, con) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |-> (con)) \
        else $error("mecanum wheel mixer check failed");

// next-cycle implication
`define MWM_ASSERT_NEXT(lbl, ant, con) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |=> (con)) \
        else $error("mecanum wheel mixer check failed");

`endif

/* hdl/mwm_pkg.sv */
// types, constants and control structs of the mecanum wheel mixer
`timescale 1ns / 1ps

package mwm_pkg;

    localparam int unsigned CFG_DATA_W     = 16;
    localparam int unsigned CFG_IDX_W      = 2;
    localparam int unsigned NUM_WHEELS     = 4;
    localparam int unsigned WHEEL_IDX_W    = 2;
    localparam int unsigned MIX_W          = 18;
    localparam int unsigned MAG_W          = 17;
    localparam int unsigned QUO_W          = 16;
    localparam int unsigned PROD_W         = MAG_W + QUO_W;
    localparam int unsigned BIT_CNT_W      = 4;
    localparam int unsigned DUTY_WIDTH_DEF = 16;

    localparam logic [CFG_IDX_W-1:0] REG_PWM_MAX  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PWM_MIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THR      = 2'd2;

    localparam logic [CFG_DATA_W-1:0] PWM_MAX_RST = 16'd1000;
    localparam logic [CFG_DATA_W-1:0] PWM_MIN_RST = 16'd0;
    localparam logic [CFG_DATA_W-1:0] THR_RST     = 16'd6554;

    typedef struct packed {
        logic signed [15:0] pitch;
        logic signed [15:0] roll;
        logic signed [15:0] yaw;
        logic [15:0]        throttle;
        logic               armed;
    } t_in_item;

    typedef struct packed {
        logic        dir_front_left;
        logic [15:0] duty_front_left;
        logic        dir_front_right;
        logic [15:0] duty_front_right;
        logic        dir_rear_left;
        logic [15:0] duty_rear_left;
        logic        dir_rear_right;
        logic [15:0] duty_rear_right;
    } t_out_item;

    typedef struct packed {
        logic                   load_in;
        logic                   find_max;
        logic                   mul;
        logic                   div_step;
        logic                   div_last;
        logic                   fill;
        logic                   load_out;
        logic [WHEEL_IDX_W-1:0] wheel;
    } t_dp_cmd;

    typedef struct packed {
        logic run;
    } t_dp_stat;

endpackage

/* hdl/mwm_dp.sv */
// datapath: mixes, largest magnitude, multiply and restoring divider, output register
`timescale 1ns / 1ps

module mwm_dp #(
    parameter int unsigned DUTY_WIDTH = mwm_pkg::DUTY_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mwm_pkg::t_dp_cmd                    i_cmd,
    output mwm_pkg::t_dp_stat                   o_stat,
    input  mwm_pkg::t_in_item                   i_in_item,
    input  logic                                i_cfg_we,
    input  logic [mwm_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [mwm_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output mwm_pkg::t_out_item                  o_out_item
);
    import mwm_pkg::*;

    localparam logic [32:0] DUTY_LIM = (33'd1 << DUTY_WIDTH) - 33'd1;

    function automatic logic [DUTY_WIDTH-1:0] sat_duty(input logic [QUO_W-1:0] v);
        logic [32:0] wide;
        begin
            wide = 33'(v);
            if (wide > DUTY_LIM) begin
                wide = DUTY_LIM;
            end
            sat_duty = DUTY_WIDTH'(wide);
        end
    endfunction

    logic [CFG_DATA_W-1:0]       r_pwm_max;
    logic [CFG_DATA_W-1:0]       r_pwm_min;
    logic [CFG_DATA_W-1:0]       r_thr;
    logic                        r_en;
    logic signed [MIX_W-1:0]     r_mix [NUM_WHEELS];
    logic [MAG_W-1:0]            r_mag [NUM_WHEELS];
    logic [MAG_W-1:0]            r_largest;
    logic [NUM_WHEELS-1:0]       r_held;
    logic [MAG_W-1:0]            r_rem;
    logic [QUO_W-1:0]            r_quo;
    logic [DUTY_WIDTH-1:0]       r_duty [NUM_WHEELS];
    t_out_item                   r_out;

    logic signed [MIX_W-1:0]     s_p;
    logic signed [MIX_W-1:0]     s_r;
    logic signed [MIX_W-1:0]     s_y;
    logic [MAG_W-1:0]            s_mag [NUM_WHEELS];
    logic [NUM_WHEELS-1:0]       s_dir;
    logic [MAG_W-1:0]            s_max01;
    logic [MAG_W-1:0]            s_max23;
    logic [MAG_W-1:0]            s_largest;
    logic [PROD_W-1:0]           s_prod;
    logic [MAG_W:0]              s_trial;
    logic [MAG_W:0]              s_diff;
    logic [MAG_W-1:0]            n_rem;
    logic [QUO_W-1:0]            n_quo;

    assign s_p = MIX_W'($signed(i_in_item.pitch));
    assign s_r = MIX_W'($signed(i_in_item.roll));
    assign s_y = MIX_W'($signed(i_in_item.yaw));

    always_comb begin
        for (int k = 0; k < NUM_WHEELS; k++) begin
            s_dir[k] = ~r_mix[k][MIX_W-1];
            s_mag[k] = r_mix[k][MIX_W-1] ? MAG_W'(-r_mix[k]) : MAG_W'(r_mix[k]);
        end
        s_max01   = (s_mag[1] > s_mag[0]) ? s_mag[1] : s_mag[0];
        s_max23   = (s_mag[3] > s_mag[2]) ? s_mag[3] : s_mag[2];
        s_largest = (s_max23 > s_max01) ? s_max23 : s_max01;
    end

    assign s_prod = PROD_W'(r_mag[i_cmd.wheel]) * PROD_W'(r_pwm_max);

    // one restoring step: remainder stays below the divisor
    always_comb begin
        s_trial = {r_rem, r_quo[QUO_W-1]};
        s_diff  = s_trial - {1'b0, r_largest};
        if (!s_diff[MAG_W]) begin
            n_rem = s_diff[MAG_W-1:0];
            n_quo = {r_quo[QUO_W-2:0], 1'b1};
        end else begin
            n_rem = s_trial[MAG_W-1:0];
            n_quo = {r_quo[QUO_W-2:0], 1'b0};
        end
    end

    assign o_stat.run = r_en && (r_largest != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pwm_max <= PWM_MAX_RST;
            r_pwm_min <= PWM_MIN_RST;
            r_thr     <= THR_RST;
            r_held    <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_PWM_MAX: r_pwm_max <= i_cfg_data;
                    REG_PWM_MIN: r_pwm_min <= i_cfg_data;
                    REG_THR:     r_thr     <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.find_max && r_en) begin
                r_held <= s_dir;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_en     <= i_in_item.armed && (i_in_item.throttle > r_thr);
            r_mix[0] <= s_p + s_r + s_y;
            r_mix[1] <= -s_p + s_r + s_y;
            r_mix[2] <= -s_p + s_r - s_y;
            r_mix[3] <= s_p + s_r - s_y;
        end
        if (i_cmd.find_max) begin
            r_mag     <= s_mag;
            r_largest <= s_largest;
        end
        // high product bits seed the remainder, low bits shift out through the quotient
        if (i_cmd.mul) begin
            r_rem <= s_prod[PROD_W-1:QUO_W];
            r_quo <= s_prod[QUO_W-1:0];
        end else if (i_cmd.div_step) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
        if (i_cmd.div_step && i_cmd.div_last) begin
            r_duty[i_cmd.wheel] <= sat_duty(n_quo);
        end
        if (i_cmd.fill) begin
            for (int k = 0; k < NUM_WHEELS; k++) begin
                r_duty[k] <= r_en ? DUTY_WIDTH'(0) : sat_duty(r_pwm_min);
            end
        end
        if (i_cmd.load_out) begin
            r_out.dir_front_left   <= r_held[0];
            r_out.duty_front_left  <= 16'(r_duty[0]);
            r_out.dir_front_right  <= r_held[1];
            r_out.duty_front_right <= 16'(r_duty[1]);
            r_out.dir_rear_left    <= r_held[2];
            r_out.duty_rear_left   <= 16'(r_duty[2]);
            r_out.dir_rear_right   <= r_held[3];
            r_out.duty_rear_right  <= 16'(r_duty[3]);
        end
    end

    assign o_out_item = r_out;

endmodule

/* hdl/mwm_ctrl.sv */
// controller: mix, max search, four multiply-divide passes or a fill, output transfer
`timescale 1ns / 1ps

module mwm_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  mwm_pkg::t_dp_stat  i_stat,
    output mwm_pkg::t_dp_cmd   o_cmd
);
    import mwm_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MAX  = 5'b00010,
        S_MUL  = 5'b00100,
        S_DIV  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    localparam logic [BIT_CNT_W-1:0]   LAST_BIT   = BIT_CNT_W'(QUO_W - 1);
    localparam logic [WHEEL_IDX_W-1:0] LAST_WHEEL = WHEEL_IDX_W'(NUM_WHEELS - 1);

    t_state                  r_state, n_state;
    logic [WHEEL_IDX_W-1:0]  r_wheel, n_wheel;
    logic [BIT_CNT_W-1:0]    r_bit, n_bit;
    logic                    r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_wheel     = r_wheel;
        n_bit       = r_bit;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_cmd.wheel = r_wheel;
        o_in_ready  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_in = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_MAX;
                end
            end
            S_MAX: begin
                o_cmd.find_max = 1'b1;
                n_wheel        = '0;
                n_state        = S_MUL;
            end
            S_MUL: begin
                // disabled output or all mixes zero skip the divider
                if (i_stat.run) begin
                    o_cmd.mul = 1'b1;
                    n_bit     = '0;
                    n_state   = S_DIV;
                end else begin
                    o_cmd.fill = 1'b1;
                    n_state    = S_DONE;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_bit          = r_bit + 1'b1;
                if (r_bit == LAST_BIT) begin
                    o_cmd.div_last = 1'b1;
                    if (r_wheel == LAST_WHEEL) begin
                        n_state = S_DONE;
                    end else begin
                        n_wheel = r_wheel + 1'b1;
                        n_state = S_MUL;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wheel     <= '0;
            r_bit       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wheel     <= n_wheel;
            r_bit       <= n_bit;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

/* hdl/mecanum_wheel_mixer.sv */
// Mecanum wheel mixer: one remote-control sample in, four wheel duties and directions out.
// Each sample forms the four wheel mixes, takes the largest magnitude and scales every
// wheel to |mix| * pwm_max / largest, truncated, with one shared 17x16 multiplier and a
// restoring divider that resolves one quotient bit per cycle. An enabled sample with a
// nonzero mix runs in steps: the transfer cycle latches the mixes, then comes the
// largest-magnitude search, per wheel one multiply and the divide steps, and last the
// load of the output register; no new sample is taken before that load.
// A disabled sample (not armed, or throttle not above the threshold) or one with all
// mixes zero skips the divider. The result sits in an output register, so the next
// sample is accepted while a result still waits to be taken; if that result is still
// waiting when the next one is ready, the block holds in its output-load cycle until
// the waiting result is taken. Configuration writes land at once.
`timescale 1ns / 1ps

module mecanum_wheel_mixer #(
    parameter int unsigned DUTY_WIDTH = mwm_pkg::DUTY_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  mwm_pkg::t_in_item               i_in_item,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output mwm_pkg::t_out_item              o_out_item,
    input  logic                            i_cfg_we,
    input  logic [mwm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [mwm_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import mwm_pkg::*;

    t_dp_cmd  s_cmd;
    t_dp_stat s_stat;

    mwm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (s_stat),
        .o_cmd       (s_cmd)
    );

    mwm_dp #(
        .DUTY_WIDTH (DUTY_WIDTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (s_cmd),
        .o_stat     (s_stat),
        .i_in_item  (i_in_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_out_item (o_out_item)
    );

endmodule

/* hdl/mwm_checker.sv */
// port-level checks of the mecanum wheel mixer and their binding to the top level
`timescale 1ns / 1ps
`include "mecanum_wheel_mixer_macros.svh"

module mwm_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input mwm_pkg::t_out_item o_out_item
);
    import mwm_pkg::*;

    // a waiting result stays up and unchanged
    `MWM_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid)
    `MWM_ASSERT_NEXT(a_out_stable, o_out_valid && !i_out_ready, $stable(o_out_item))

    // an input transfer always starts a busy stretch
    `MWM_ASSERT_NEXT(a_busy_after_in, i_in_valid && o_in_ready, !o_in_ready)

    // a new result appears only as the block finishes an item
    `MWM_ASSERT_NOW(a_out_from_work, $rose(o_out_valid), $past(!o_in_ready))

endmodule

bind mecanum_wheel_mixer mwm_checker u_mwm_checker (.*);

/* tb/testbench.sv */
// self-checking testbench for the mecanum wheel mixer: directed corners, then random phases
`timescale 1ns / 1ps

module testbench;
    import mwm_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int unsigned IDLE_PCT = 34;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    t_in_item   i_in_item = '0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    t_out_item  o_out_item;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // shadow of the block's registers and held direction bits
    logic [15:0] cfg_pwm_max = PWM_MAX_RST;
    logic [15:0] cfg_pwm_min = PWM_MIN_RST;
    logic [15:0] cfg_thr = THR_RST;
    logic [3:0]  held_dirs = 4'b0000;

    t_out_item pending_wheels[$];
    int unsigned mismatch_count = 0;
    bit steady = 1'b0;

    mecanum_wheel_mixer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("testbench: errors");
        $finish;
    end

    always @(negedge i_clk) begin
        i_out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    // mixes, largest magnitude, scaled duties; updates the held directions
    function automatic t_out_item predict_wheels(t_in_item s);
        int mix[4];
        int unsigned mag[4];
        int unsigned largest;
        logic [15:0] duty[4];
        longint unsigned scaled;
        int p;
        int r;
        int y;
        t_out_item res;
        p = $signed(s.pitch);
        r = $signed(s.roll);
        y = $signed(s.yaw);
        mix[0] = p + r + y;
        mix[1] = -p + r + y;
        mix[2] = -p + r - y;
        mix[3] = p + r - y;
        largest = 0;
        for (int k = 0; k < 4; k++) begin
            mag[k] = (mix[k] < 0) ? -mix[k] : mix[k];
            if (mag[k] > largest) largest = mag[k];
        end
        if (s.armed && s.throttle > cfg_thr) begin
            for (int k = 0; k < 4; k++) begin
                held_dirs[k] = (mix[k] >= 0);
                if (largest == 0) begin
                    duty[k] = 16'd0;
                end else begin
                    scaled = longint'(mag[k]) * cfg_pwm_max / largest;
                    duty[k] = (scaled > 65535) ? 16'hFFFF : scaled[15:0];
                end
            end
        end else begin
            for (int k = 0; k < 4; k++) duty[k] = cfg_pwm_min;
        end
        res.dir_front_left   = held_dirs[0];
        res.duty_front_left  = duty[0];
        res.dir_front_right  = held_dirs[1];
        res.duty_front_right = duty[1];
        res.dir_rear_left    = held_dirs[2];
        res.duty_rear_left   = duty[2];
        res.dir_rear_right   = held_dirs[3];
        res.duty_rear_right  = duty[3];
        return res;
    endfunction

    always @(posedge i_clk) begin : out_check
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_wheels.size() == 0) begin
                report_mismatch("result with nothing pending", 0, 0);
            end else begin
                want = pending_wheels.pop_front();
                if (o_out_item.dir_front_left !== want.dir_front_left)
                    report_mismatch("dir_front_left", o_out_item.dir_front_left,
                                    want.dir_front_left);
                if (o_out_item.duty_front_left !== want.duty_front_left)
                    report_mismatch("duty_front_left", o_out_item.duty_front_left,
                                    want.duty_front_left);
                if (o_out_item.dir_front_right !== want.dir_front_right)
                    report_mismatch("dir_front_right", o_out_item.dir_front_right,
                                    want.dir_front_right);
                if (o_out_item.duty_front_right !== want.duty_front_right)
                    report_mismatch("duty_front_right", o_out_item.duty_front_right,
                                    want.duty_front_right);
                if (o_out_item.dir_rear_left !== want.dir_rear_left)
                    report_mismatch("dir_rear_left", o_out_item.dir_rear_left,
                                    want.dir_rear_left);
                if (o_out_item.duty_rear_left !== want.duty_rear_left)
                    report_mismatch("duty_rear_left", o_out_item.duty_rear_left,
                                    want.duty_rear_left);
                if (o_out_item.dir_rear_right !== want.dir_rear_right)
                    report_mismatch("dir_rear_right", o_out_item.dir_rear_right,
                                    want.dir_rear_right);
                if (o_out_item.duty_rear_right !== want.duty_rear_right)
                    report_mismatch("duty_rear_right", o_out_item.duty_rear_right,
                                    want.duty_rear_right);
            end
        end
    end

    // one input transfer; valid is left high for a back-to-back follower
    task automatic send_sample(t_in_item s);
        @(negedge i_clk);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= s;
        do @(posedge i_clk); while (!o_in_ready);
        pending_wheels.push_back(predict_wheels(s));
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_wheels.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            REG_PWM_MAX: cfg_pwm_max = data;
            REG_PWM_MIN: cfg_pwm_min = data;
            REG_THR:     cfg_thr = data;
            default: ;
        endcase
    endtask

    function automatic t_in_item make_sample(logic [15:0] p, logic [15:0] r, logic [15:0] y,
                                             logic [15:0] thr, logic armed);
        t_in_item s;
        s.pitch    = p;
        s.roll     = r;
        s.yaw      = y;
        s.throttle = thr;
        s.armed    = armed;
        return s;
    endfunction

    // command values biased toward the extremes and toward zero
    function automatic logic [15:0] rand_cmd();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'($urandom_range(0, 15)) - 16'd8;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_default_registers();
        send_sample(make_sample(16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 1'b1));
        send_sample(make_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, THR_RST + 16'd1, 1'b1));
        send_sample(make_sample(16'h8000, 16'h8000, 16'h8000, 16'hFFFF, 1'b1));
        // throttle equal to the threshold keeps the wheels off
        send_sample(make_sample(16'h1234, 16'h0100, 16'hFF00, THR_RST, 1'b1));
        send_sample(make_sample(16'h7FFF, 16'h0000, 16'h0000, 16'hFFFF, 1'b0));
        send_sample(make_sample(16'h0000, -16'sd100, 16'h0000, 16'hFFFF, 1'b1));
        send_sample(make_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1));
        send_sample(make_sample(16'h0001, 16'h0000, 16'h0000, 16'h8000, 1'b1));
        send_sample(make_sample(16'h0000, 16'h0000, 16'h8000, 16'hFFFF, 1'b1));
        send_sample(make_sample(16'h5555, 16'hAAAA, 16'h0F0F, 16'h0000, 1'b0));
        wait_drained();
    endtask

    task automatic test_register_extremes();
        write_reg(REG_PWM_MAX, 16'hFFFF);
        write_reg(REG_PWM_MIN, 16'hFFFF);
        write_reg(REG_THR, 16'h0000);
        send_sample(make_sample(16'h7FFF, 16'h8000, 16'h0005, 16'h0001, 1'b1));
        send_sample(make_sample(16'h7FFF, 16'h7FFF, 16'h8000, 16'h0000, 1'b1));
        send_sample(make_sample(16'h4000, 16'h2000, 16'h1000, 16'hFFFF, 1'b0));
        wait_drained();
        // a write past the register list must change nothing
        write_reg(REG_UNUSED, 16'h1234);
        send_sample(make_sample(16'hC000, 16'h3FFF, 16'h0001, 16'h0001, 1'b1));
        wait_drained();
        write_reg(REG_THR, 16'hFFFF);
        send_sample(make_sample(16'h0100, 16'h0200, 16'h0300, 16'hFFFF, 1'b1));
        wait_drained();
        write_reg(REG_PWM_MAX, 16'h0000);
        write_reg(REG_PWM_MIN, 16'h0001);
        write_reg(REG_THR, 16'h0000);
        send_sample(make_sample(16'd100, -16'sd3, 16'd7, 16'h0001, 1'b1));
        send_sample(make_sample(16'h8000, 16'h7FFF, 16'h8000, 16'h0000, 1'b1));
        wait_drained();
    endtask

    task automatic random_phase(logic [15:0] pmax, logic [15:0] pmin, logic [15:0] thr,
                                int n, bit no_idle, bit mid_pause);
        t_in_item s;
        write_reg(REG_PWM_MAX, pmax);
        write_reg(REG_PWM_MIN, pmin);
        write_reg(REG_THR, thr);
        steady = no_idle;
        for (int k = 0; k < n; k++) begin
            if (mid_pause && k == n / 2) wait_drained();
            s.pitch = rand_cmd();
            s.roll  = rand_cmd();
            s.yaw   = rand_cmd();
            if ($urandom_range(0, 99) < 80 && cfg_thr != 16'hFFFF) begin
                s.armed    = 1'b1;
                s.throttle = 16'($urandom_range(int'(cfg_thr) + 1, 65535));
            end else begin
                s.armed    = 1'($urandom);
                s.throttle = 16'($urandom);
            end
            send_sample(s);
        end
        wait_drained();
        steady = 1'b0;
    endtask

    task automatic test_random_traffic();
        random_phase(PWM_MAX_RST, PWM_MIN_RST, THR_RST, 200, 1'b0, 1'b0);
        random_phase(16'hFFFF, 16'hFFFF, 16'h0000, 180, 1'b1, 1'b0);
        random_phase(16'h0001, 16'h0007, 16'h8000, 150, 1'b0, 1'b0);
        random_phase(16'($urandom), 16'($urandom), 16'($urandom_range(0, 40000)),
                     200, 1'b0, 1'b1);
        random_phase(16'hFFFF, 16'h0000, 16'hFFFE, 150, 1'b0, 1'b0);
        random_phase(16'($urandom_range(0, 255)), 16'($urandom), 16'($urandom),
                     200, 1'b0, 1'b0);
    endtask

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (4) @(posedge i_clk);
        test_default_registers();
        test_register_extremes();
        test_random_traffic();
        wait_drained();
        repeat (80) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
